// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, muted while reset is high
`define SMJ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every rising edge, reset included
`define SMJ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/smj_pkg.sv =====
// shared types and codes of the sort merge join core
package smj_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int KEY_W = 64;
  localparam int ROW_W = 32;
  localparam int ST_W  = 3;

  // operation codes
  localparam logic [1:0] OP_LOAD_L = 2'd0;
  localparam logic [1:0] OP_LOAD_R = 2'd1;
  localparam logic [1:0] OP_FETCH  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // status codes
  localparam logic [ST_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [ST_W-1:0] ST_PAIR     = 3'd1;
  localparam logic [ST_W-1:0] ST_DONE     = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
  localparam logic [ST_W-1:0] ST_ORDER    = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ROW_W-1:0] row;
  } entry_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

// ===== rtl/smj_ram.sv =====
// one table: simple dual port memory with registered read data
module smj_ram
  import smj_pkg::*;
#(
  parameter int DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  entry_t                   wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output entry_t                   rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/smj_cmp.sv =====
// shared 64 bit key comparator
module smj_cmp
  import smj_pkg::*;
(
  input  logic [KEY_W-1:0] a,
  input  logic [KEY_W-1:0] b,
  output cmp_res_t         res
);

  assign res.eq = (a == b);
  assign res.lt = (a < b);

endmodule

// ===== rtl/smj_ctrl.sv =====
// sequencer: loads, group scans, merge steps and pair output
module smj_ctrl
  import smj_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     operation,
  input  logic [KEY_W-1:0]               key,
  input  logic [ROW_W-1:0]               row_id,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ROW_W-1:0]               left_row,
  output logic [ROW_W-1:0]               right_row,
  output logic [ST_W-1:0]                status,
  output logic                           we_l,
  output logic                           we_r,
  output logic [$clog2(TABLE_DEPTH)-1:0] waddr,
  output entry_t                         wdata,
  output logic [$clog2(TABLE_DEPTH)-1:0] raddr_l,
  output logic [$clog2(TABLE_DEPTH)-1:0] raddr_r,
  input  entry_t                         rdata_l,
  input  entry_t                         rdata_r,
  output logic [KEY_W-1:0]               cmp_a,
  output logic [KEY_W-1:0]               cmp_b,
  input  cmp_res_t                       cmp_res
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE = CW'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_PAIR, S_FIND, S_KEYS, S_SCAN_L, S_CHK_L,
    S_SCAN_R, S_CHK_R, S_MATCH, S_PUT
  } state_t;

  state_t state;

  logic [CW-1:0] lc, rc, lgs, lge, rgs, rge, lcur, rcur;
  logic          in_prod;
  logic [KEY_W-1:0] lk, rk, last_lkey, last_rkey;
  logic [ROW_W-1:0] res_left, res_right;
  logic [ST_W-1:0]  res_status;

  logic             accept, is_load, side_r, slot_free;
  logic [CW-1:0]    cnt_sel;
  logic             full, order_bad, load_ok;
  logic             pair_ok, groups_left;
  logic             fin;
  logic             out_load;
  logic [ROW_W-1:0] fin_left, fin_right;
  logic [ST_W-1:0]  fin_status;
  logic [CW-1:0]    rcur_next, lcur_next;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && (state == S_IDLE);
  assign slot_free = !out_valid || !out_stall;
  assign out_load  = (fin || (state == S_PUT)) && slot_free;
  assign is_load   = (operation == OP_LOAD_L) || (operation == OP_LOAD_R);
  assign side_r    = (operation == OP_LOAD_R);
  assign cnt_sel   = side_r ? rc : lc;
  assign full      = (cnt_sel >= FULL_CNT);
  assign order_bad = (cnt_sel != '0) && cmp_res.lt;
  assign load_ok   = accept && is_load && !full && !order_bad;

  assign we_l  = load_ok && !side_r;
  assign we_r  = load_ok && side_r;
  assign waddr = cnt_sel[AW-1:0];
  assign wdata = '{key: key, row: row_id};

  assign pair_ok     = in_prod && (lcur < lc) && (rcur < rc);
  assign groups_left = (lgs < lc) && (rgs < rc);
  assign rcur_next   = rcur + ONE;
  assign lcur_next   = lcur + ONE;

  // read addresses and comparator operands by step
  always_comb begin
    raddr_l = lcur[AW-1:0];
    raddr_r = rcur[AW-1:0];
    cmp_a   = lk;
    cmp_b   = rk;
    unique case (state)
      S_IDLE: begin
        cmp_a = key;
        cmp_b = side_r ? last_rkey : last_lkey;
      end
      S_FIND, S_MATCH: begin
        raddr_l = lgs[AW-1:0];
        raddr_r = rgs[AW-1:0];
      end
      S_SCAN_L: raddr_l = lge[AW-1:0];
      S_SCAN_R: raddr_r = rge[AW-1:0];
      S_CHK_L: begin
        cmp_a = rdata_l.key;
        cmp_b = lk;
      end
      S_CHK_R: begin
        cmp_a = rdata_r.key;
        cmp_b = rk;
      end
      default: begin
      end
    endcase
  end

  // result of the current item, when this step ends it
  always_comb begin
    fin        = 1'b0;
    fin_left   = '0;
    fin_right  = '0;
    fin_status = ST_DONE;
    unique case (state)
      S_IDLE: begin
        if (accept && is_load) begin
          fin        = 1'b1;
          fin_status = full ? ST_FULL : (order_bad ? ST_ORDER : ST_ACCEPTED);
        end else if (accept && operation == OP_CLEAR) begin
          fin        = 1'b1;
          fin_status = ST_ACCEPTED;
        end
      end
      S_PAIR: begin
        fin = 1'b1;
        if (pair_ok) begin
          fin_left   = rdata_l.row;
          fin_right  = rdata_r.row;
          fin_status = ST_PAIR;
        end
      end
      S_FIND: fin = !groups_left;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      lc        <= '0;
      rc        <= '0;
      lgs       <= '0;
      lge       <= '0;
      rgs       <= '0;
      rge       <= '0;
      lcur      <= '0;
      rcur      <= '0;
      in_prod   <= 1'b0;
    end else begin
      // output register: loaded with a new word or emptied once taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (fin) begin
        if (slot_free) begin
          left_row  <= fin_left;
          right_row <= fin_right;
          status    <= fin_status;
          state     <= S_IDLE;
        end else begin
          res_left   <= fin_left;
          res_right  <= fin_right;
          res_status <= fin_status;
          state      <= S_PUT;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (operation == OP_FETCH) begin
              state <= in_prod ? S_PAIR : S_FIND;
            end else begin
              lgs     <= '0;
              lge     <= '0;
              rgs     <= '0;
              rge     <= '0;
              lcur    <= '0;
              rcur    <= '0;
              in_prod <= 1'b0;
              if (operation == OP_CLEAR) begin
                lc <= '0;
                rc <= '0;
              end
            end
            if (we_l) begin
              lc        <= lc + ONE;
              last_lkey <= key;
            end
            if (we_r) begin
              rc        <= rc + ONE;
              last_rkey <= key;
            end
          end
        end
        S_PAIR: begin
          if (pair_ok) begin
            // right side runs fastest, left advances at the group end
            if (rcur_next >= rge) begin
              rcur <= rgs;
              if (lcur_next >= lge) begin
                in_prod <= 1'b0;
                lgs     <= lge;
                rgs     <= rge;
              end else begin
                lcur <= lcur_next;
              end
            end else begin
              rcur <= rcur_next;
            end
          end else begin
            in_prod <= 1'b0;
          end
        end
        S_FIND: begin
          if (groups_left) begin
            state <= S_KEYS;
          end
        end
        S_KEYS: begin
          lk    <= rdata_l.key;
          rk    <= rdata_r.key;
          lge   <= lgs + ONE;
          rge   <= rgs + ONE;
          state <= S_SCAN_L;
        end
        S_SCAN_L: state <= (lge < lc) ? S_CHK_L : S_SCAN_R;
        S_CHK_L: begin
          if (cmp_res.eq) begin
            lge   <= lge + ONE;
            state <= S_SCAN_L;
          end else begin
            state <= S_SCAN_R;
          end
        end
        S_SCAN_R: state <= (rge < rc) ? S_CHK_R : S_MATCH;
        S_CHK_R: begin
          if (cmp_res.eq) begin
            rge   <= rge + ONE;
            state <= S_SCAN_R;
          end else begin
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          if (cmp_res.eq) begin
            lcur    <= lgs;
            rcur    <= rgs;
            in_prod <= 1'b1;
            state   <= S_PAIR;
          end else if (cmp_res.lt) begin
            lgs   <= lge;
            state <= S_FIND;
          end else begin
            rgs   <= rge;
            state <= S_FIND;
          end
        end
        S_PUT: begin
          if (slot_free) begin
            left_row  <= res_left;
            right_row <= res_right;
            status    <= res_status;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/sort_merge_join_core.sv =====
// sort merge equi-join core: two sorted tables and a merge sequencer
//
// input channel (in_valid / in_stall): one word per command, operation
//   selects load left, load right, fetch next pair or clear; key and row_id
//   only matter for loads
// output channel (out_valid / out_stall): exactly one word per command,
//   left_row, right_row and status; row fields are zero unless status is pair
// steps: load and clear are answered straight from idle; a fetch inside a
//   cross product does one read of each table; a fetch that has to find the
//   next matching group runs merge steps that read both group heads, and
//   group end scans that read and compare one entry at a time; this is
//   set by the single read port of each table and the one shared key
//   comparator
// one command is in flight at a time; in_stall is high while it runs
// a finished word sits in the output register; the next command is taken
//   while it waits, and if that one finishes before the word is taken, the
//   sequencer holds its answer and stalls until the output frees up
// reset clears both table counts and the merge position; table contents
//   are not cleared and are only read below the counts
module sort_merge_join_core
  import smj_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       operation,
  input  logic [KEY_W-1:0] key,
  input  logic [ROW_W-1:0] row_id,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ROW_W-1:0] left_row,
  output logic [ROW_W-1:0] right_row,
  output logic [ST_W-1:0]  status
);

  localparam int AW = $clog2(TABLE_DEPTH);

  // table write port, shared address since only one side loads at a time
  logic          we_l, we_r;
  logic [AW-1:0] waddr;
  entry_t        wdata;

  // table read ports
  logic [AW-1:0] raddr_l, raddr_r;
  entry_t        rdata_l, rdata_r;

  // shared comparator: order check on loads, group scans, merge decision
  logic [KEY_W-1:0] cmp_a, cmp_b;
  cmp_res_t         cmp_res;

  smj_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .key       (key),
    .row_id    (row_id),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .left_row  (left_row),
    .right_row (right_row),
    .status    (status),
    .we_l      (we_l),
    .we_r      (we_r),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr_l   (raddr_l),
    .raddr_r   (raddr_r),
    .rdata_l   (rdata_l),
    .rdata_r   (rdata_r),
    .cmp_a     (cmp_a),
    .cmp_b     (cmp_b),
    .cmp_res   (cmp_res)
  );

  // left table: key and row id side by side
  smj_ram #(
    .DEPTH (TABLE_DEPTH)
  ) u_ram_l (
    .clk   (clk),
    .we    (we_l),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_l),
    .rdata (rdata_l)
  );

  // right table
  smj_ram #(
    .DEPTH (TABLE_DEPTH)
  ) u_ram_r (
    .clk   (clk),
    .we    (we_r),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_r),
    .rdata (rdata_r)
  );

  smj_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

endmodule

// ===== rtl/smj_chk.sv =====
// port level checker for the join core and its bind
`include "assert_macros.svh"

module smj_chk
  import smj_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [ROW_W-1:0] left_row,
  input logic [ROW_W-1:0] right_row,
  input logic [ST_W-1:0]  status
);

  `SMJ_ASSERT(a_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(status) && $stable(left_row) && $stable(right_row), "stalled output word changed")
  `SMJ_ASSERT(a_zero_rows, clk, rst, out_valid && status != ST_PAIR |-> left_row == '0 && right_row == '0, "row fields set on a non-pair word")
  `SMJ_ASSERT(a_status, clk, rst, out_valid |-> status == ST_ACCEPTED || status == ST_PAIR || status == ST_DONE || status == ST_FULL || status == ST_ORDER, "undefined status code")
  `SMJ_ASSERT_ALWAYS(a_reset, clk, $past(rst) && !rst |-> !out_valid && !in_stall, "block not idle after reset")

endmodule

bind sort_merge_join_core smj_chk u_smj_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .left_row  (left_row),
  .right_row (right_row),
  .status    (status)
);

// ===== verif/tb_sort_merge_join_core.sv =====
// self-checking testbench of the sort merge join core with a merge-join predictor
module tb_sort_merge_join_core;
  import smj_pkg::*;

  localparam int DEPTH        = TABLE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1750;
  localparam int STALL_LIMIT  = 200000;  // cycles with no word moving on either side
  localparam int LONG_HOLD    = 200;     // receiver hold-off that backs the block up
  localparam int HOLD_AFTER   = 400;     // output words seen before the long hold-off
  localparam int QUIET_TAIL   = 150;     // last commands run with no idling at all
  localparam int DRAIN_CYCLES = 40;

  // one command word and one answer word
  typedef struct {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [ROW_W-1:0] row;
  } join_cmd_t;

  typedef struct {
    logic [ROW_W-1:0] left_row;
    logic [ROW_W-1:0] right_row;
    logic [ST_W-1:0]  status;
  } join_word_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       operation = OP_CLEAR;
  logic [KEY_W-1:0] key = '0;
  logic [ROW_W-1:0] row_id = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ROW_W-1:0] left_row;
  logic [ROW_W-1:0] right_row;
  logic [ST_W-1:0]  status;

  sort_merge_join_core #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .operation(operation),
    .key      (key),
    .row_id   (row_id),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .left_row (left_row),
    .right_row(right_row),
    .status   (status)
  );

  // ---------------------------------------------------------------------------
  // join predictor: its own copy of both tables and of the merge position
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] lkey_mem [DEPTH];
  logic [ROW_W-1:0] lrow_mem [DEPTH];
  logic [KEY_W-1:0] rkey_mem [DEPTH];
  logic [ROW_W-1:0] rrow_mem [DEPTH];
  int lcount, rcount;
  int lgrp_lo, lgrp_hi, rgrp_lo, rgrp_hi;  // current equal-key groups, end exclusive
  int lpos, rpos;                          // position inside the cross product
  bit product_on;

  // any load or clear sends the merge back to the first entries
  function automatic void rewind_join();
    lgrp_lo = 0;
    lgrp_hi = 0;
    rgrp_lo = 0;
    rgrp_hi = 0;
    lpos = 0;
    rpos = 0;
    product_on = 1'b0;
  endfunction

  // first index past the run of keys equal to the one at start
  function automatic int group_limit(bit right_side, int start);
    int e;
    e = start + 1;
    if (right_side) begin
      while (e < rcount && rkey_mem[e] == rkey_mem[start]) e++;
    end else begin
      while (e < lcount && lkey_mem[e] == lkey_mem[start]) e++;
    end
    return e;
  endfunction

  // full check comes before the order check; rejected loads still rewind
  function automatic logic [ST_W-1:0] append_entry(bit right_side, logic [KEY_W-1:0] k,
                                                  logic [ROW_W-1:0] r);
    int n;
    logic [ST_W-1:0] st;
    n = right_side ? rcount : lcount;
    if (n >= DEPTH) begin
      st = ST_FULL;
    end else if (n > 0 && k < (right_side ? rkey_mem[n-1] : lkey_mem[n-1])) begin
      st = ST_ORDER;
    end else begin
      st = ST_ACCEPTED;
      if (right_side) begin
        rkey_mem[n] = k;
        rrow_mem[n] = r;
        rcount++;
      end else begin
        lkey_mem[n] = k;
        lrow_mem[n] = r;
        lcount++;
      end
    end
    rewind_join();
    return st;
  endfunction

  // skip unmatched groups until both sides sit on the same key
  function automatic void seek_group();
    logic [KEY_W-1:0] lk, rk;
    while (!product_on && lgrp_lo < lcount && rgrp_lo < rcount) begin
      lk = lkey_mem[lgrp_lo];
      rk = rkey_mem[rgrp_lo];
      lgrp_hi = group_limit(1'b0, lgrp_lo);
      rgrp_hi = group_limit(1'b1, rgrp_lo);
      if (lk == rk) begin
        lpos = lgrp_lo;
        rpos = rgrp_lo;
        product_on = 1'b1;
      end else if (lk < rk) begin
        lgrp_lo = lgrp_hi;
      end else begin
        rgrp_lo = rgrp_hi;
      end
    end
  endfunction

  function automatic join_word_t predict_answer(join_cmd_t c);
    join_word_t w;
    w.left_row  = '0;
    w.right_row = '0;
    w.status    = ST_ACCEPTED;
    case (c.op)
      OP_LOAD_L: w.status = append_entry(1'b0, c.key, c.row);
      OP_LOAD_R: w.status = append_entry(1'b1, c.key, c.row);
      OP_CLEAR: begin
        lcount = 0;
        rcount = 0;
        rewind_join();
      end
      OP_FETCH: begin
        if (!product_on) seek_group();
        if (product_on && lpos < lcount && rpos < rcount) begin
          // left-major walk of the cross product
          w.left_row  = lrow_mem[lpos];
          w.right_row = rrow_mem[rpos];
          w.status    = ST_PAIR;
          rpos++;
          if (rpos >= rgrp_hi) begin
            rpos = rgrp_lo;
            lpos++;
            if (lpos >= lgrp_hi) begin
              product_on = 1'b0;
              lgrp_lo = lgrp_hi;
              rgrp_lo = rgrp_hi;
            end
          end
        end else begin
          product_on = 1'b0;
          w.status = ST_DONE;
        end
      end
    endcase
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // command words waiting to go out and answers still owed by the block
  // ---------------------------------------------------------------------------
  join_cmd_t  cmd_q[$];
  join_word_t answers_q[$];
  logic [KEY_W-1:0] gen_lkeys[$];  // keys the generator knows were appended
  logic [KEY_W-1:0] gen_rkeys[$];

  int  total_cmds = 0;
  int  cmds_taken = 0;
  int  words_seen = 0;
  int  err_cnt = 0;
  bit  in_taken = 1'b0;    // command word accepted at the last rising edge
  bit  tail_phase = 1'b0;  // no idling on either side from here on
  int  send_gap = 0;
  int  hold_cnt = 0;
  bit  long_hold_done = 1'b0;
  int  stuck_cycles = 0;
  join_cmd_t drv_cmd;

  function automatic logic [KEY_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // keys climb by a random step or repeat to build equal-key groups
  function automatic logic [KEY_W-1:0] next_key(logic [KEY_W-1:0] k,
                                               logic [KEY_W-1:0] step_max);
    if ($urandom_range(0, 2) == 0) return k;
    return k + 64'd1 + (rand64() % step_max);
  endfunction

  task automatic push_cmd(logic [1:0] op, logic [KEY_W-1:0] k, logic [ROW_W-1:0] r);
    join_cmd_t c;
    c.op  = op;
    c.key = k;
    c.row = r;
    cmd_q.push_back(c);
  endtask

  task automatic flag_error(string what, join_word_t want, join_word_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch (%s) at output word %0d: exp left %h right %h status %0d,",
               what, words_seen, want.left_row, want.right_row, want.status,
               " got left %h right %h status %0d", got.left_row, got.right_row, got.status);
  endtask

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // stimulus build, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int phase, nl, nr, li, ri, noise_odds, pairs, nf, i, j, ie, je;
    bit big_right, side;
    logic [KEY_W-1:0] step_max, start, lk, rk, last;

    lcount = 0;
    rcount = 0;
    rewind_join();

    // directed: empty tables, key and row extremes, equal keys, order reject,
    // group cross products, finished join, restart by a rejected load, clear
    push_cmd(OP_FETCH, rand64(), $urandom);        // both tables empty
    push_cmd(OP_LOAD_L, '0, '0);
    push_cmd(OP_FETCH, rand64(), $urandom);        // right table still empty
    push_cmd(OP_LOAD_R, '0, '1);
    push_cmd(OP_LOAD_L, '0, 32'h1);                // equal key is taken
    push_cmd(OP_LOAD_L, 64'd7, $urandom);
    push_cmd(OP_LOAD_L, 64'd3, $urandom);          // below last key
    push_cmd(OP_LOAD_R, 64'd5, $urandom);
    push_cmd(OP_LOAD_L, '1, '1);
    push_cmd(OP_LOAD_R, '1, $urandom);
    push_cmd(OP_LOAD_R, '1, 32'h8000_0001);
    repeat (6) push_cmd(OP_FETCH, rand64(), $urandom);  // four pairs, then finished
    push_cmd(OP_LOAD_R, 64'd1, $urandom);          // rejected, still restarts the join
    repeat (2) push_cmd(OP_FETCH, rand64(), $urandom);
    push_cmd(OP_CLEAR, rand64(), $urandom);
    push_cmd(OP_FETCH, rand64(), $urandom);

    // random phases: clear, two sorted tables loaded in mixed order with some
    // noise, then fetches that mostly run the join out; phase one fills a table
    phase = 0;
    while (cmd_q.size() < 22 + RANDOM_ITEMS) begin
      push_cmd(OP_CLEAR, rand64(), $urandom);
      gen_lkeys.delete();
      gen_rkeys.delete();
      big_right = $urandom_range(0, 1);
      if (phase == 1) begin
        nl = big_right ? $urandom_range(4, 24) : DEPTH + $urandom_range(1, 3);
        nr = big_right ? DEPTH + $urandom_range(1, 3) : $urandom_range(4, 24);
        noise_odds = 200;
      end else begin
        nl = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
        nr = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
        noise_odds = 10;
      end
      case ($urandom_range(0, 3))
        0:       step_max = 64'd1;
        1:       step_max = 64'd3;
        2:       step_max = 64'd16;
        default: step_max = 64'h1_0000_0000;  // mostly unmatched groups
      endcase
      // leave headroom so the key streams never wrap
      start = rand64();
      if (step_max > 64'd16) start[KEY_W-1] = 1'b0;
      else if (start > 64'hFFFF_FFFF_FFF0_0000) start = start - 64'h10_0000;
      lk = start;
      rk = start;
      li = 0;
      ri = 0;
      while (li < nl || ri < nr) begin
        if ($urandom_range(1, noise_odds) == 1) begin
          // noise: a key below the table's last one, or a fetch mid-load
          side = $urandom_range(0, 1);
          last = '0;
          if (side && gen_rkeys.size() > 0) last = gen_rkeys[$];
          if (!side && gen_lkeys.size() > 0) last = gen_lkeys[$];
          if (last != 0 && $urandom_range(0, 1) == 1)
            push_cmd(side ? OP_LOAD_R : OP_LOAD_L, last - 64'd1 - (rand64() % last), $urandom);
          else
            push_cmd(OP_FETCH, rand64(), $urandom);
        end else if (ri >= nr || (li < nl &&
                     $urandom_range(0, nl + nr - li - ri - 1) < nl - li)) begin
          lk = next_key(lk, step_max);
          push_cmd(OP_LOAD_L, lk, $urandom);
          if (gen_lkeys.size() < DEPTH) gen_lkeys.push_back(lk);
          li++;
        end else begin
          rk = next_key(rk, step_max);
          push_cmd(OP_LOAD_R, rk, $urandom);
          if (gen_rkeys.size() < DEPTH) gen_rkeys.push_back(rk);
          ri++;
        end
      end
      // size of the join, to know how many fetches run it out
      pairs = 0;
      i = 0;
      j = 0;
      while (i < gen_lkeys.size() && j < gen_rkeys.size()) begin
        if (gen_lkeys[i] < gen_rkeys[j]) begin
          i++;
        end else if (gen_lkeys[i] > gen_rkeys[j]) begin
          j++;
        end else begin
          ie = i;
          je = j;
          while (ie < gen_lkeys.size() && gen_lkeys[ie] == gen_lkeys[i]) ie++;
          while (je < gen_rkeys.size() && gen_rkeys[je] == gen_rkeys[j]) je++;
          pairs += (ie - i) * (je - j);
          i = ie;
          j = je;
        end
      end
      // now and then stop partway through the join
      nf = ($urandom_range(0, 4) == 0) ? $urandom_range(0, pairs) : pairs + $urandom_range(1, 3);
      repeat (nf) push_cmd(OP_FETCH, rand64(), $urandom);
      phase++;
    end
    total_cmds = cmd_q.size();

    repeat (6) @(negedge clk);
    rst = 1'b0;

    // every command taken and every answer back, then a short drain
    while (cmds_taken < total_cmds || answers_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && answers_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: next command word at the falling edge, held while stalled
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (cmd_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        // idle burst before the next command
        send_gap = $urandom_range(0, 2);
        in_valid <= 1'b0;
      end else begin
        drv_cmd = cmd_q.pop_front();
        operation <= drv_cmd.op;
        key       <= drv_cmd.key;
        row_id    <= drv_cmd.row;
        in_valid  <= 1'b1;
      end
    end
  end

  // receiver: short random stalls, plus one long hold-off that fills the block
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && words_seen >= HOLD_AFTER) begin
      long_hold_done = 1'b1;
      hold_cnt = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
      hold_cnt = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check answer words first, then predict for a newly taken command
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    join_word_t got, want;
    join_cmd_t  taken;
    in_taken = !rst && in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      got.left_row  = left_row;
      got.right_row = right_row;
      got.status    = status;
      words_seen++;
      if (answers_q.size() == 0) begin
        want = '{default: '0};
        flag_error("no word expected", want, got);
      end else begin
        want = answers_q.pop_front();
        if (got.left_row !== want.left_row || got.right_row !== want.right_row ||
            got.status !== want.status)
          flag_error("field", want, got);
      end
    end
    if (in_taken) begin
      taken.op  = operation;
      taken.key = key;
      taken.row = row_id;
      answers_q.push_back(predict_answer(taken));
      cmds_taken++;
    end
    tail_phase = (total_cmds - cmds_taken) <= QUIET_TAIL;
  end

  // watchdog: ends the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
